[sv/lfua_pkg.sv]
package lfua_pkg;

  // Field widths of the request and response beats.
  localparam int ID_W     = 16;
  localparam int UNIT_F_W = 3;
  localparam int STAT_W   = 2;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Response status codes.
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE_RD,
    ST_FREE_CMP,
    ST_DONE
  } state_t;

endpackage

[sv/lowest_free_unit_allocator.sv]
// An allocate walks the units in ascending order from unit 0 and stops at the
// first free unit or at the last one; a free reads the owner memory (ST_FREE_RD)
// and then compares (ST_FREE_CMP) for each unit walked in ascending order.
// One request at a time: a new beat is accepted only in ST_IDLE, after the result
// has been handed to the output register, so an output stall also holds off the next beat.
// Reset (synchronous, active low) marks every unit free; owner memory is not cleared.
module lowest_free_unit_allocator #(
  parameter int MAX_UNITS  = 8,
  parameter int OWNER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [lfua_pkg::ID_W-1:0]     in_owner_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfua_pkg::UNIT_F_W-1:0] out_unit_number,
  output logic [lfua_pkg::STAT_W-1:0]   out_status
);

  // Only the low OWNER_BITS of the 16-bit tag are kept and compared.
  localparam int OWN_W  = (OWNER_BITS < lfua_pkg::ID_W) ? OWNER_BITS : lfua_pkg::ID_W;
  localparam int UNIT_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam logic [UNIT_W-1:0] LAST_UNIT = UNIT_W'(MAX_UNITS - 1);

  lfua_pkg::state_t state_r, state_nxt;

  logic [MAX_UNITS-1:0]  in_use_r;
  logic [UNIT_W-1:0]     idx_r;
  logic [OWN_W-1:0]      who_r;
  logic [OWN_W-1:0]      rd_data_r;
  logic [lfua_pkg::UNIT_F_W-1:0] res_unit_r;
  logic [lfua_pkg::STAT_W-1:0]   res_status_r;
  logic                  out_valid_r;
  logic [lfua_pkg::UNIT_F_W-1:0] out_unit_r;
  logic [lfua_pkg::STAT_W-1:0]   out_status_r;

  // Owner table.
  logic [OWN_W-1:0] owner_mem [MAX_UNITS];

  logic in_fire;
  logic out_free;
  logic hit_free;
  logic hit_owner;
  logic is_last;
  logic [UNIT_W+2:0] idx_ext;

  // Control decoded from the state.
  logic do_set;
  logic do_clear;
  logic do_step;
  logic res_ok;
  logic res_full;
  logic res_miss;
  logic do_out_load;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != lfua_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign hit_free  = !in_use_r[idx_r];
  assign hit_owner = in_use_r[idx_r] && (rd_data_r == who_r);
  assign is_last   = (idx_r == LAST_UNIT);
  assign idx_ext   = {3'b000, idx_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfua_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_kind == lfua_pkg::KIND_ALLOC) ? lfua_pkg::ST_ALLOC
                                                       : lfua_pkg::ST_FREE_RD;
        end
      end
      lfua_pkg::ST_ALLOC: begin
        if (hit_free || is_last) state_nxt = lfua_pkg::ST_DONE;
      end
      lfua_pkg::ST_FREE_RD: state_nxt = lfua_pkg::ST_FREE_CMP;
      lfua_pkg::ST_FREE_CMP: begin
        if (hit_owner || is_last) state_nxt = lfua_pkg::ST_DONE;
        else state_nxt = lfua_pkg::ST_FREE_RD;
      end
      lfua_pkg::ST_DONE: begin
        if (out_free) state_nxt = lfua_pkg::ST_IDLE;
      end
      default: state_nxt = lfua_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    do_set      = 1'b0;
    do_clear    = 1'b0;
    do_step     = 1'b0;
    res_ok      = 1'b0;
    res_full    = 1'b0;
    res_miss    = 1'b0;
    do_out_load = 1'b0;
    case (state_r)
      lfua_pkg::ST_ALLOC: begin
        if (hit_free) begin
          do_set = 1'b1;
          res_ok = 1'b1;
        end else if (is_last) begin
          res_full = 1'b1;
        end else begin
          do_step = 1'b1;
        end
      end
      lfua_pkg::ST_FREE_CMP: begin
        if (hit_owner) begin
          do_clear = 1'b1;
          res_ok   = 1'b1;
        end else if (is_last) begin
          res_miss = 1'b1;
        end else begin
          do_step = 1'b1;
        end
      end
      lfua_pkg::ST_DONE: do_out_load = out_free;
      default: ;
    endcase
  end

  // State register and unit flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfua_pkg::ST_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_set)   in_use_r[idx_r] <= 1'b1;
      if (do_clear) in_use_r[idx_r] <= 1'b0;
      if (do_out_load)   out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Walk index, request capture and result hold.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r <= '0;
      who_r <= in_owner_id[OWN_W-1:0];
    end else if (do_step) begin
      idx_r <= idx_r + 1'b1;
    end
    if (res_ok) begin
      res_unit_r   <= idx_ext[2:0];
      res_status_r <= lfua_pkg::STATUS_OK;
    end else if (res_full) begin
      res_unit_r   <= '0;
      res_status_r <= lfua_pkg::STATUS_FULL;
    end else if (res_miss) begin
      res_unit_r   <= '0;
      res_status_r <= lfua_pkg::STATUS_NOT_FOUND;
    end
    if (do_out_load) begin
      out_unit_r   <= res_unit_r;
      out_status_r <= res_status_r;
    end
  end

  // Owner memory: written on allocate, read one unit per step on free.
  always_ff @(posedge clk) begin
    if (do_set) owner_mem[idx_r] <= who_r;
    rd_data_r <= owner_mem[idx_r];
  end

  assign out_valid       = out_valid_r;
  assign out_unit_number = out_unit_r;
  assign out_status      = out_status_r;

endmodule

[dv/lowest_free_unit_allocator_checker.sv]
module lowest_free_unit_allocator_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_kind,
  input  logic [lfua_pkg::ID_W-1:0]     in_owner_id,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lfua_pkg::UNIT_F_W-1:0] out_unit_number,
  input  logic [lfua_pkg::STAT_W-1:0]   out_status,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS = 8;

  // One expected response beat.
  typedef struct packed {
    logic [lfua_pkg::UNIT_F_W-1:0] unit;
    logic [lfua_pkg::STAT_W-1:0]   status;
  } grant_t;

  // Shadow copy of the unit table.
  logic                      unit_busy [UNITS];
  logic [lfua_pkg::ID_W-1:0] unit_tag  [UNITS];

  grant_t expected_grants[$];
  int     error_total = 0;
  int     queued      = 0;
  int     grants_seen = 0;

  assign fail_count    = error_total;
  assign pending_count = queued;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_total++;
  endtask

  // Applies one request to the shadow table and returns the response it causes.
  function automatic grant_t serve_request(logic kind, logic [lfua_pkg::ID_W-1:0] who);
    grant_t g;
    g.unit = '0;
    if (kind == lfua_pkg::KIND_ALLOC) begin
      g.status = lfua_pkg::STATUS_FULL;
      for (int u = 0; u < UNITS; u++) begin
        if (!unit_busy[u]) begin
          unit_busy[u] = 1'b1;
          unit_tag[u]  = who;
          g.unit       = u[lfua_pkg::UNIT_F_W-1:0];
          g.status     = lfua_pkg::STATUS_OK;
          break;
        end
      end
    end else begin
      g.status = lfua_pkg::STATUS_NOT_FOUND;
      for (int u = 0; u < UNITS; u++) begin
        if (unit_busy[u] && unit_tag[u] == who) begin
          unit_busy[u] = 1'b0;
          g.unit       = u[lfua_pkg::UNIT_F_W-1:0];
          g.status     = lfua_pkg::STATUS_OK;
          break;
        end
      end
    end
    return g;
  endfunction

  // Responses are retired before the request of the same edge is queued;
  // a response can never belong to a request accepted at the same edge.
  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      for (int u = 0; u < UNITS; u++) begin
        unit_busy[u] = 1'b0;
        unit_tag[u]  = '0;
      end
      expected_grants.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("response beat %0d with no request pending", grants_seen));
        end else begin
          want = expected_grants.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("beat %0d status: expected %0d, got %0d",
                                      grants_seen, want.status, out_status));
          if (out_unit_number !== want.unit)
            report_mismatch($sformatf("beat %0d unit_number: expected %0d, got %0d",
                                      grants_seen, want.unit, out_unit_number));
        end
        grants_seen++;
      end
      if (in_valid && !in_stall)
        expected_grants.push_back(serve_request(in_kind, in_owner_id));
    end
    queued <= expected_grants.size();
  end

endmodule

[dv/lowest_free_unit_allocator_tb.sv]
module lowest_free_unit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;

  typedef logic [lfua_pkg::ID_W-1:0] owner_t;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic                          in_kind         = lfua_pkg::KIND_ALLOC;
  logic [lfua_pkg::ID_W-1:0]     in_owner_id     = '0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [lfua_pkg::UNIT_F_W-1:0] out_unit_number;
  logic [lfua_pkg::STAT_W-1:0]   out_status;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_pending  = 1'b0;
  int cycle_count   = 0;

  logic [lfua_pkg::ID_W-1:0] owner_pool [6];

  always #5 clk = ~clk;

  lowest_free_unit_allocator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_owner_id     (in_owner_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_unit_number (out_unit_number),
    .out_status      (out_status)
  );

  lowest_free_unit_allocator_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_owner_id     (in_owner_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_unit_number (out_unit_number),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  // Offers one request beat, waits until it is taken, then maybe idles.
  task automatic offer_request(logic kind, logic [lfua_pkg::ID_W-1:0] who);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_owner_id <= who;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      in_kind     <= 1'($urandom_range(1));
      in_owner_id <= owner_t'($urandom_range(16'hFFFF));
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  // Edge cases: empty table, full table, repeated owners, extreme ids.
  task automatic run_directed();
    offer_request(lfua_pkg::KIND_FREE,  16'h0000);  // Nothing held yet.
    offer_request(lfua_pkg::KIND_ALLOC, 16'h0000);
    offer_request(lfua_pkg::KIND_ALLOC, 16'hFFFF);
    offer_request(lfua_pkg::KIND_ALLOC, 16'hFFFF);
    offer_request(lfua_pkg::KIND_ALLOC, 16'hA5A5);
    offer_request(lfua_pkg::KIND_ALLOC, 16'h5A5A);
    offer_request(lfua_pkg::KIND_ALLOC, 16'h0001);
    offer_request(lfua_pkg::KIND_ALLOC, 16'h8000);
    offer_request(lfua_pkg::KIND_ALLOC, 16'hFFFF);  // Last free unit.
    offer_request(lfua_pkg::KIND_ALLOC, 16'h1234);  // Table full.
    offer_request(lfua_pkg::KIND_FREE,  16'h1234);  // Unknown owner while full.
    offer_request(lfua_pkg::KIND_FREE,  16'hFFFF);  // Lowest of three units of one owner.
    offer_request(lfua_pkg::KIND_ALLOC, 16'h1234);  // Reuses the hole just made.
    offer_request(lfua_pkg::KIND_FREE,  16'hFFFF);
    offer_request(lfua_pkg::KIND_FREE,  16'hFFFF);
    offer_request(lfua_pkg::KIND_FREE,  16'hFFFF);  // Owner holds nothing now.
    offer_request(lfua_pkg::KIND_FREE,  16'h0000);
    offer_request(lfua_pkg::KIND_FREE,  16'h1234);
    offer_request(lfua_pkg::KIND_FREE,  16'hA5A5);
    offer_request(lfua_pkg::KIND_FREE,  16'h5A5A);
    offer_request(lfua_pkg::KIND_FREE,  16'h0001);
    offer_request(lfua_pkg::KIND_FREE,  16'h8000);
    offer_request(lfua_pkg::KIND_FREE,  16'h8000);  // Empty again.
  endtask

  // Mostly a small owner pool so that frees hit, with an alloc bias that
  // drifts so the table swings between empty and full.
  task automatic run_random(int count);
    int                        alloc_pct;
    logic                      kind;
    logic [lfua_pkg::ID_W-1:0] who;
    alloc_pct = 50;
    foreach (owner_pool[i]) owner_pool[i] = owner_t'($urandom_range(16'hFFFF));
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: begin
            alloc_pct = 30;
          end
          1: begin
            alloc_pct = 50;
          end
          default: begin
            alloc_pct = 75;
          end
        endcase
      end
      kind = ($urandom_range(99) < alloc_pct) ? lfua_pkg::KIND_ALLOC : lfua_pkg::KIND_FREE;
      if ($urandom_range(7) == 0)
        who = owner_t'($urandom_range(16'hFFFF));
      else
        who = owner_pool[3'($urandom_range(5))];
      offer_request(kind, who);
    end
  endtask

  // Response side: random stall, or a long hold-off when one is requested.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Reset, stimulus phases and verdict.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 63;
    hold_pending  = 1'b1;
    run_directed();
    run_random(667);

    send_idle_pct = 63;
    recv_idle_pct = 14;
    run_random(667);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_pending  = 1'b1;
    run_random(666);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && pending_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
